### rtl/core/oets_pkg.sv
package oets_pkg;

  localparam int OETS_DEPTH = 64;
  localparam int KEY_W = 32;

  typedef struct packed {
    logic [KEY_W-1:0] key_bits;
    logic             is_final;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             end_of_set;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic pair_en;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  // Maps float bits to an unsigned value whose order is the float order.
  function automatic logic [KEY_W-1:0] order_value(input logic [KEY_W-1:0] bits);
    logic [KEY_W-1:0] res;
    if (bits[KEY_W-2:0] == '0) begin
      res = {1'b1, {(KEY_W-1){1'b0}}};
    end else if (bits[KEY_W-1]) begin
      res = ~bits;
    end else begin
      res = {1'b1, bits[KEY_W-2:0]};
    end
    return res;
  endfunction

endpackage

### rtl/core/oets_cell.sv
module oets_cell
  import oets_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] key_in,
  input  logic [KEY_W-1:0] left_key,
  input  logic [KEY_W-1:0] right_key,
  input  logic             left_swap,
  output logic [KEY_W-1:0] key_o,
  output logic             swap_o
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             gt;

  assign gt     = order_value(key_r) > order_value(right_key);
  assign swap_o = ctrl.pair_en & gt;
  assign key_o  = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.load) begin
      key_nxt = key_in;
    end else if (ctrl.shift || swap_o) begin
      key_nxt = right_key;
    end else if (left_swap) begin
      key_nxt = left_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

### rtl/core/odd_even_transposition_sorter.sv
// Sorts a set of up to DEPTH single-precision keys held in a row of cells, one
// key per cell. Keys are loaded one per cycle while no set is being sorted or
// emitted; the key flagged final closes the set, and a key that arrives while
// the row is full is dropped. Each cycle of sorting is one phase of
// compare-exchanges between neighboring cells, an even phase and then an odd
// phase making one pass, and sorting ends after the first pass with no
// exchange. The keys then leave in ascending float order, one per transfer,
// with end_of_set on the largest. No new key is taken from the final key until
// the last result has been transferred.
module odd_even_transposition_sorter
  import oets_pkg::*;
#(
  parameter int DEPTH = OETS_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t          state_r;
  state_t          state_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [CW-1:0]   left_r;
  logic [CW-1:0]   left_nxt;
  logic            phase_r;
  logic            phase_nxt;
  logic            swap_r;
  logic            swap_nxt;

  logic            in_xfer;
  logic            out_xfer;
  logic            load_en;
  logic            sorting;
  logic            shift_en;
  logic            swap_any;

  cell_ctrl_t       ctrl   [DEPTH];
  logic [KEY_W-1:0] keys   [DEPTH];
  logic [DEPTH-1:0] swaps;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign swap_any = |swaps;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_W-1:0] left_key;
      logic [KEY_W-1:0] right_key;
      logic             left_swap;

      if (gi == 0) begin : g_first
        assign left_key  = '0;
        assign left_swap = 1'b0;
      end else begin : g_mid
        assign left_key  = keys[gi-1];
        assign left_swap = swaps[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign right_key = keys[gi];
      end else begin : g_next
        assign right_key = keys[gi+1];
      end

      assign ctrl[gi].load    = load_en && (count_r == CW'(gi));
      assign ctrl[gi].pair_en = sorting && (phase_r == gi[0]) && (CW'(gi + 1) < count_r);
      assign ctrl[gi].shift   = shift_en;

      oets_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl[gi]),
        .key_in    (in_data.key_bits),
        .left_key  (left_key),
        .right_key (right_key),
        .left_swap (left_swap),
        .key_o     (keys[gi]),
        .swap_o    (swaps[gi])
      );
    end
  endgenerate

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    sorting   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
      end
      ST_SORT: begin
        sorting = 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    load_en  = in_xfer && (count_r < CW'(DEPTH));
    shift_en = out_xfer;
  end

  assign out_data.sorted_key = keys[0];
  assign out_data.end_of_set = (left_r == CW'(1));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    phase_nxt = phase_r;
    swap_nxt  = swap_r;
    case (state_r)
      ST_LOAD: begin
        if (load_en) begin
          count_nxt = count_r + CW'(1);
        end
        if (in_xfer && in_data.is_final) begin
          state_nxt = ST_SORT;
          phase_nxt = 1'b0;
          swap_nxt  = 1'b0;
        end
      end
      ST_SORT: begin
        if (!phase_r) begin
          swap_nxt  = swap_any;
          phase_nxt = 1'b1;
        end else if (!(swap_r || swap_any)) begin
          state_nxt = ST_EMIT;
          left_nxt  = count_r;
        end else begin
          swap_nxt  = 1'b0;
          phase_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          left_nxt = left_r - CW'(1);
          if (left_r == CW'(1)) begin
            state_nxt = ST_LOAD;
            count_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      left_r  <= '0;
      phase_r <= 1'b0;
      swap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      phase_r <= phase_nxt;
      swap_r  <= swap_nxt;
    end
  end

endmodule
